>>> rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg: shared types and constants for the triangle tangent unit
// Field widths, fixed-point constants, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package ttc_pkg;
    localparam int POS_W  = 24;
    localparam int TEX_W  = 16;
    localparam int OUT_W  = 16;
    localparam int DIR_W  = 43;   // direction magnitude width; signed component is DIR_W+1 bits
    localparam int MAG_W  = 24;   // magnitude after normalizing shift
    localparam int LEN2_W = 50;   // sum of three 24-bit squares
    localparam int RAD_W  = 62;   // len2 << 12
    localparam int ROOT_W = 31;
    localparam int NUM_W  = 45;   // (a << 20) + r/2, carry included
    localparam int QUO_W  = 45;
    localparam logic [OUT_W-1:0] UNIT_Q14 = 16'd16384;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PROD  = 9'b000000010,
        ST_DIR   = 9'b000000100,
        ST_SHIFT = 9'b000001000,
        ST_SQ    = 9'b000010000,
        ST_SQRT  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_EMIT  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } seq_state_t;

    // control from sequencer to serial divider
    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/ttc_if.sv
// ----------------------------------------------------------------------------
// ttc_in_if / ttc_out_if: request channels of the tangent unit
// Valid/ready handshake with the corner or result payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ttc_in_if #(parameter int INDEX_BITS = 20);
    logic                    valid;
    logic                    ready;
    logic [INDEX_BITS-1:0]   vertex_index;
    logic signed [23:0]      pos_x;
    logic signed [23:0]      pos_y;
    logic signed [23:0]      pos_z;
    logic signed [15:0]      tex_u;
    logic signed [15:0]      tex_v;
    modport source (output valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                    input ready);
    modport sink (input valid, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  output ready);
endinterface

interface ttc_out_if #(parameter int INDEX_BITS = 20);
    logic                    valid;
    logic                    ready;
    logic [INDEX_BITS-1:0]   target_index;
    logic signed [15:0]      tangent_x;
    logic signed [15:0]      tangent_y;
    logic signed [15:0]      tangent_z;
    logic                    degenerate;
    logic                    last_of_triangle;
    modport source (output valid, target_index, tangent_x, tangent_y, tangent_z,
                    degenerate, last_of_triangle, input ready);
    modport sink (input valid, target_index, tangent_x, tangent_y, tangent_z,
                  degenerate, last_of_triangle, output ready);
endinterface
`default_nettype wire

>>> rtl/ttc_mul.sv
// ----------------------------------------------------------------------------
// ttc_mul: bit-serial signed multiplier
// Shift-add, one multiplier bit per cycle; 25 x 25 bit signed operands.
// ----------------------------------------------------------------------------
`default_nettype none
module ttc_mul
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [24:0] a,
    input  wire logic signed [24:0] b,
    output logic                    busy,
    output logic signed [49:0]      p
);
    logic signed [49:0] acc_reg, acc_next;
    logic signed [49:0] mcand_reg, mcand_next;
    logic [24:0]        mplr_reg, mplr_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;

    always_comb
    begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            acc_next   = '0;
            mcand_next = 50'(a);
            mplr_next  = b;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of a two's complement multiplier has negative weight
            if (mplr_reg[0])
            begin
                if (cnt_reg == 5'd24)
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplr_next  = mplr_reg >> 1;
            cnt_next   = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
    end

    assign busy = busy_reg;
    assign p    = acc_reg;
endmodule
`default_nettype wire

>>> rtl/ttc_sqrt.sv
// ----------------------------------------------------------------------------
// ttc_sqrt: digit-serial integer square root
// Two radicand bits per cycle, one root bit per cycle (restoring).
// ----------------------------------------------------------------------------
`default_nettype none
module ttc_sqrt
    import ttc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [RAD_W-1:0]   radicand,
    output logic                    busy,
    output logic [ROOT_W-1:0]       root
);
    localparam int STEPS = RAD_W / 2;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] shifted;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

>>> rtl/ttc_div.sv
// ----------------------------------------------------------------------------
// ttc_div: bit-serial restoring divider
// One quotient bit per cycle, unsigned NUM_W / ROOT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none
module ttc_div
    import ttc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire div_ctl_t           ctl_in,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [ROOT_W-1:0]  den,
    output logic                    busy,
    output logic [QUO_W-1:0]        quo
);
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [ROOT_W:0]   shifted;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[ROOT_W-1:0], num_reg[NUM_W-1]};
        if (ctl_in.start)
        begin
            num_next  = num;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (shifted >= {1'b0, den})
            begin
                rem_next = shifted - {1'b0, den};
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NUM_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

>>> rtl/triangle_tangent_calc.sv
// ----------------------------------------------------------------------------
// triangle_tangent_calc: per-triangle unit tangent from positions and UVs
// Buffers two corners, computes the tangent on the third, emits three results.
// ----------------------------------------------------------------------------
// Corners arrive one request at a time. The first two are stored as they are
// accepted. The third starts the tangent sequence, during which no input is
// taken: eight products on a bit-serial 25x25 multiplier, a normalizing
// shift of one bit per cycle, a squaring pass for the three magnitudes
// (another three products), a 31-step square root and three 45-step serial
// divisions, one per component. A degenerate triangle skips from the
// direction step straight to the results. The three results then leave one
// per output request, in corner order, with the last one marked. A zero UV
// determinant or a zero direction gives a zero tangent with the degenerate
// flag.
`default_nettype none
module triangle_tangent_calc
    import ttc_pkg::*;
#(
    parameter int INDEX_BITS = 20
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ttc_in_if.sink    in_ch,
    ttc_out_if.source out_ch
);
    // corner store
    logic [1:0]            cnt_reg;
    logic [INDEX_BITS-1:0] idx_reg [3];
    logic signed [POS_W-1:0] px_reg [3];
    logic signed [POS_W-1:0] py_reg [3];
    logic signed [POS_W-1:0] pz_reg [3];
    logic signed [TEX_W-1:0] tu_reg [3];
    logic signed [TEX_W-1:0] tv_reg [3];

    seq_state_t state_reg;
    logic [3:0] step_reg;      // product number or component number
    logic       go_reg;        // launch pending for the current step
    logic [1:0] emit_reg;

    // differences (17 bit tex, 25 bit pos)
    logic signed [16:0] du1, dv1, du2, dv2;
    logic signed [24:0] dp1 [3];
    logic signed [24:0] dp2 [3];
    always_comb
    begin
        du1 = 17'(tu_reg[1]) - 17'(tu_reg[0]);
        dv1 = 17'(tv_reg[1]) - 17'(tv_reg[0]);
        du2 = 17'(tu_reg[2]) - 17'(tu_reg[0]);
        dv2 = 17'(tv_reg[2]) - 17'(tv_reg[0]);
        dp1[0] = 25'(px_reg[1]) - 25'(px_reg[0]);
        dp2[0] = 25'(px_reg[2]) - 25'(px_reg[0]);
        dp1[1] = 25'(py_reg[1]) - 25'(py_reg[0]);
        dp2[1] = 25'(py_reg[2]) - 25'(py_reg[0]);
        dp1[2] = 25'(pz_reg[1]) - 25'(pz_reg[0]);
        dp2[2] = 25'(pz_reg[2]) - 25'(pz_reg[0]);
    end

    // serial multiplier
    logic               mul_start, mul_busy;
    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] mul_p;
    ttc_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
                   .busy(mul_busy), .p(mul_p));

    logic signed [49:0]     prod_reg [8];
    logic signed [DIR_W:0]  dir_reg [3];
    logic [MAG_W-1:0]       mag_reg [3];
    logic [LEN2_W-1:0]      len2_reg;
    logic                   flip_reg, degen_reg;
    logic [OUT_W-1:0]       q_reg [3];

    // operand select: products 0..1 det, 2..7 direction, 8..10 squares
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0: begin mul_a = 25'(du1); mul_b = 25'(dv2); end
            4'd1: begin mul_a = 25'(du2); mul_b = 25'(dv1); end
            4'd2: begin mul_a = 25'(dv2); mul_b = dp1[0]; end
            4'd3: begin mul_a = 25'(dv1); mul_b = dp2[0]; end
            4'd4: begin mul_a = 25'(dv2); mul_b = dp1[1]; end
            4'd5: begin mul_a = 25'(dv1); mul_b = dp2[1]; end
            4'd6: begin mul_a = 25'(dv2); mul_b = dp1[2]; end
            4'd7: begin mul_a = 25'(dv1); mul_b = dp2[2]; end
            4'd8: begin mul_a = {1'b0, mag_reg[0]}; mul_b = {1'b0, mag_reg[0]}; end
            4'd9: begin mul_a = {1'b0, mag_reg[1]}; mul_b = {1'b0, mag_reg[1]}; end
            4'd10: begin mul_a = {1'b0, mag_reg[2]}; mul_b = {1'b0, mag_reg[2]}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // shift search: one bit per cycle until the largest magnitude fits 24 bits
    logic [DIR_W-1:0] absd [3];
    logic [DIR_W-1:0] wide_reg [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            absd[i] = dir_reg[i][DIR_W] ? DIR_W'(-dir_reg[i]) : dir_reg[i][DIR_W-1:0];
    end
    logic fits;
    assign fits = ((wide_reg[0] | wide_reg[1] | wide_reg[2]) >> MAG_W) == '0;

    // root and divider
    logic              sq_start, sq_busy;
    logic [ROOT_W-1:0] root;
    ttc_sqrt u_sqrt (.clk, .rst_n, .start(sq_start), .radicand({len2_reg, 12'd0}),
                     .busy(sq_busy), .root(root));

    div_ctl_t         div_ctl;
    logic             div_busy;
    logic [QUO_W-1:0] quo;
    logic [NUM_W-1:0] div_num;
    logic [1:0]       comp;
    assign comp    = step_reg[1:0];
    // numerator can carry past 44 bits when a is close to 2^24
    assign div_num = NUM_W'({mag_reg[comp], 20'd0}) + NUM_W'(root >> 1);
    ttc_div u_div (.clk, .rst_n, .ctl_in(div_ctl), .num(div_num), .den(root),
                   .busy(div_busy), .quo(quo));

    logic accept_in;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept_in   = in_ch.valid && in_ch.ready;

    always_comb
    begin
        mul_start     = 1'b0;
        sq_start      = 1'b0;
        div_ctl.start = 1'b0;
        if (go_reg)
        begin
            unique case (state_reg)
                ST_PROD, ST_SQ: mul_start = 1'b1;
                ST_SQRT:        sq_start = 1'b1;
                ST_DIV:         div_ctl.start = 1'b1;
                default:        ;
            endcase
        end
    end

    logic signed [DIR_W:0] det_val;
    assign det_val = (DIR_W+1)'(prod_reg[0]) - (DIR_W+1)'(prod_reg[1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            go_reg    <= 1'b0;
            emit_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        if (cnt_reg == 2'd2)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_PROD;
                            step_reg  <= '0;
                            go_reg    <= 1'b1;
                        end
                        else
                            cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                ST_PROD:
                begin
                    go_reg <= 1'b0;
                    if (!go_reg && !mul_busy)
                    begin
                        if (step_reg == 4'd7)
                            state_reg <= ST_DIR;
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                            go_reg   <= 1'b1;
                        end
                    end
                end
                ST_DIR:
                begin
                    if (det_val == '0 || (dir_reg[0] == '0 && dir_reg[1] == '0
                                          && dir_reg[2] == '0))
                    begin
                        state_reg <= ST_EMIT;
                        emit_reg  <= '0;
                    end
                    else
                        state_reg <= ST_SHIFT;
                end
                ST_SHIFT:
                begin
                    if (fits)
                    begin
                        state_reg <= ST_SQ;
                        step_reg  <= 4'd8;
                        go_reg    <= 1'b1;
                    end
                end
                ST_SQ:
                begin
                    go_reg <= 1'b0;
                    if (!go_reg && !mul_busy)
                    begin
                        if (step_reg == 4'd10)
                        begin
                            state_reg <= ST_SQRT;
                            go_reg    <= 1'b1;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                            go_reg   <= 1'b1;
                        end
                    end
                end
                ST_SQRT:
                begin
                    go_reg <= 1'b0;
                    if (!go_reg && !sq_busy)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                        go_reg    <= 1'b1;
                    end
                end
                ST_DIV:
                begin
                    go_reg <= 1'b0;
                    if (!go_reg && !div_busy)
                    begin
                        if (step_reg == 4'd2)
                        begin
                            state_reg <= ST_EMIT;
                            emit_reg  <= '0;
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                            go_reg   <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_ch.ready)
                    begin
                        if (emit_reg == 2'd2)
                            state_reg <= ST_IDLE;
                        else
                            emit_reg <= emit_reg + 2'd1;
                    end
                end
                ST_DONE:  state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            idx_reg[cnt_reg] <= in_ch.vertex_index;
            px_reg[cnt_reg]  <= in_ch.pos_x;
            py_reg[cnt_reg]  <= in_ch.pos_y;
            pz_reg[cnt_reg]  <= in_ch.pos_z;
            tu_reg[cnt_reg]  <= in_ch.tex_u;
            tv_reg[cnt_reg]  <= in_ch.tex_v;
        end
        if (state_reg == ST_PROD && !go_reg && !mul_busy)
            prod_reg[step_reg[2:0]] <= mul_p;
        if (state_reg == ST_DIR)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wide_reg[i] <= absd[i];
                q_reg[i]    <= '0;
            end
            flip_reg  <= det_val[DIR_W];
            degen_reg <= 1'b1;
            len2_reg  <= '0;
        end
        if (state_reg == ST_PROD && !go_reg && !mul_busy && step_reg == 4'd7)
        begin
            // direction from product pairs (last product arrives now)
            dir_reg[0] <= (DIR_W+1)'(prod_reg[2]) - (DIR_W+1)'(prod_reg[3]);
            dir_reg[1] <= (DIR_W+1)'(prod_reg[4]) - (DIR_W+1)'(prod_reg[5]);
            dir_reg[2] <= (DIR_W+1)'(prod_reg[6]) - (DIR_W+1)'(mul_p);
        end
        if (state_reg == ST_SHIFT)
        begin
            if (fits)
            begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= wide_reg[i][MAG_W-1:0];
                degen_reg <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    wide_reg[i] <= wide_reg[i] >> 1;
            end
        end
        if (state_reg == ST_SQ && !go_reg && !mul_busy)
            len2_reg <= len2_reg + LEN2_W'(mul_p);
        if (state_reg == ST_DIV && !go_reg && !div_busy)
        begin
            if (quo > QUO_W'(UNIT_Q14))
                q_reg[comp] <= (dir_reg[comp][DIR_W] != flip_reg) ? -UNIT_Q14 : UNIT_Q14;
            else
                q_reg[comp] <= (dir_reg[comp][DIR_W] != flip_reg) ?
                               -quo[OUT_W-1:0] : quo[OUT_W-1:0];
        end
    end

    assign out_ch.valid            = (state_reg == ST_EMIT);
    assign out_ch.target_index     = idx_reg[emit_reg];
    assign out_ch.tangent_x        = q_reg[0];
    assign out_ch.tangent_y        = q_reg[1];
    assign out_ch.tangent_z        = q_reg[2];
    assign out_ch.degenerate       = degen_reg;
    assign out_ch.last_of_triangle = (emit_reg == 2'd2);
endmodule
`default_nettype wire

>>> rtl/ttc_checker.sv
// ----------------------------------------------------------------------------
// ttc_checker: port-level checks for the tangent unit
// Result flags and handshake behavior seen on the ports.
// ----------------------------------------------------------------------------
`default_nettype none
module ttc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        degenerate,
    input wire logic        last_of_triangle,
    input wire logic [15:0] tangent_x,
    input wire logic [15:0] tangent_y,
    input wire logic [15:0] tangent_z
);
    // a degenerate result carries a zero tangent
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> tangent_x == '0 && tangent_y == '0 && tangent_z == '0)
        else $error("degenerate result with nonzero tangent");

    // no corner is taken while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while results pending");

    // after the marked result completes, the next cycle shows no result
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_triangle |=> !out_valid)
        else $error("result after last of triangle");

    // stalled result stays valid and keeps its last flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(last_of_triangle))
        else $error("stalled result changed");
endmodule

bind triangle_tangent_calc ttc_checker u_ttc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .degenerate       (out_ch.degenerate),
    .last_of_triangle (out_ch.last_of_triangle),
    .tangent_x        (out_ch.tangent_x),
    .tangent_y        (out_ch.tangent_y),
    .tangent_z        (out_ch.tangent_z)
);
`default_nettype wire
